>>> hw/rtl/scd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the SHA-256 counter DRBG
// Round constants, initial chain values, command word, queue constants and engine states.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int unsigned KeyBytes  = 32;
    localparam int unsigned GenBytes  = 36;
    localparam int unsigned CmdDepth  = 4;
    localparam int unsigned CmdPtrW   = 2;

    typedef enum logic [0:0] {
        OP_ABSORB   = 1'b0,
        OP_GENERATE = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEYLOAD,
        ST_BYTE,
        ST_CTR,
        ST_PAD,
        ST_COMP,
        ST_COMP_WAIT,
        ST_DONE_SEED,
        ST_DONE_OUT,
        ST_REKEY,
        ST_EMIT
    } t_state;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    localparam logic [255:0] ChainIv = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage
`default_nettype wire

>>> hw/rtl/scd_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_cmd_fifo: command queue between front and back
// Small register queue holding classified input words.
// ----------------------------------------------------------------------------
module scd_cmd_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire scd_pkg::t_cmd i_cmd,
    output logic              o_full,
    input  wire logic         i_rd,
    output logic              o_empty,
    output scd_pkg::t_cmd     o_cmd
);
    scd_pkg::t_cmd r_mem [scd_pkg::CmdDepth];
    logic [scd_pkg::CmdPtrW-1:0] r_wp, r_rp;
    logic [scd_pkg::CmdPtrW:0]   r_cnt;
    logic wr_ok, rd_ok;

    assign o_full  = (r_cnt == 3'(scd_pkg::CmdDepth));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) r_wp <= r_wp + 1'b1;
            if (rd_ok) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, wr_ok} - {2'b0, rd_ok};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(scd_pkg::CmdDepth)) else $error("fifo count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !rd_ok) |=> o_full) else $error("full dropped without read");
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !wr_ok) |=> o_empty) else $error("empty dropped without write");
endmodule
`default_nettype wire

>>> hw/rtl/scd_compress.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_compress: SHA-256 compression unit
// One round per cycle, schedule in a 16-word shift line.
// ----------------------------------------------------------------------------
module scd_compress (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [511:0] i_block,
    input  wire logic [255:0] i_chain,
    output logic              o_done,
    output logic [255:0]      o_chain
);
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [255:0] r_h;
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic [31:0] e1, ch, t1, a0, mj, s0, s1, wn;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        e1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + e1 + ch + scd_pkg::round_k(r_rnd) + r_w[0];
        a0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = r_w[0] + s0 + r_w[9] + s1;
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_chain[255-32*i -: 32] = r_h[255-32*i -: 32] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511-32*i -: 32];
            for (int i = 0; i < 8; i++) r_v[i] <= i_chain[255-32*i -: 32];
            r_h <= i_chain;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + a0 + mj;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_rnd == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 1'b1;
                if (r_rnd == 6'd63) r_busy <= 1'b0;
            end
        end
    end

    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("done while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("start while busy");
endmodule
`default_nettype wire

>>> hw/rtl/scd_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_engine: DRBG back end
// Pulls commands, feeds bytes into the hash, pads, rekeys and emits words.
// ----------------------------------------------------------------------------
module scd_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_empty,
    input  wire scd_pkg::t_cmd i_cmd,
    output logic               o_cmd_rd,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [63:0]        o_random_word,
    output logic               o_word_last,
    output logic               o_was_seeded
);
    scd_pkg::t_state r_st, n_st;
    logic [255:0] r_key, r_chain, r_out;
    logic [511:0] r_buf;
    logic [63:0]  r_len;
    logic [31:0]  r_ctr;
    logic         r_seeded, r_active, r_gen, r_rekey, r_fin;
    logic [5:0]   r_idx;
    logic [2:0]   r_oc;
    logic         r_oval;
    logic [5:0]   pos;
    logic [7:0]   feed;
    logic         do_byte, comp_start, comp_done, pad_two;
    logic [255:0] comp_out;
    logic [511:0] pad_blk;

    assign pos = r_len[8:3];

    scd_compress u_comp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(comp_start),
        .i_block(r_buf), .i_chain(r_chain), .o_done(comp_done), .o_chain(comp_out)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            scd_pkg::ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.op == scd_pkg::OP_GENERATE) n_st = scd_pkg::ST_KEYLOAD;
                    else if (!r_active && r_seeded) n_st = scd_pkg::ST_KEYLOAD;
                    else n_st = scd_pkg::ST_BYTE;
                end
            end
            scd_pkg::ST_KEYLOAD: begin
                if (r_idx == 6'd31) begin
                    if (r_rekey) n_st = scd_pkg::ST_PAD;
                    else if (r_gen) n_st = scd_pkg::ST_CTR;
                    else n_st = scd_pkg::ST_BYTE;
                end
            end
            scd_pkg::ST_BYTE: n_st = (pos == 6'd63) ? scd_pkg::ST_COMP :
                                     (i_cmd.last ? scd_pkg::ST_PAD : scd_pkg::ST_IDLE);
            scd_pkg::ST_CTR: if (r_idx == 6'd3) n_st = scd_pkg::ST_PAD;
            scd_pkg::ST_PAD: n_st = scd_pkg::ST_COMP;
            scd_pkg::ST_COMP: n_st = scd_pkg::ST_COMP_WAIT;
            scd_pkg::ST_COMP_WAIT: begin
                if (comp_done) begin
                    if (r_oval) n_st = scd_pkg::ST_PAD;
                    // full seed block: keep absorbing, or pad if it held the last byte
                    else if (!r_gen && !r_fin)
                        n_st = r_active ? scd_pkg::ST_IDLE : scd_pkg::ST_PAD;
                    else if (r_gen && r_rekey) n_st = scd_pkg::ST_REKEY;
                    else if (r_gen) n_st = scd_pkg::ST_DONE_OUT;
                    else n_st = scd_pkg::ST_DONE_SEED;
                end
            end
            scd_pkg::ST_DONE_OUT: n_st = scd_pkg::ST_KEYLOAD;
            scd_pkg::ST_DONE_SEED: n_st = scd_pkg::ST_IDLE;
            scd_pkg::ST_REKEY: n_st = scd_pkg::ST_EMIT;
            scd_pkg::ST_EMIT: if (i_pop && r_oc == 3'd3) n_st = scd_pkg::ST_IDLE;
            default: n_st = scd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_rd = 1'b0;
        do_byte = 1'b0;
        comp_start = 1'b0;
        feed = 8'h00;
        case (r_st)
            scd_pkg::ST_IDLE: o_cmd_rd = !i_cmd_empty && i_cmd.op == scd_pkg::OP_GENERATE;
            scd_pkg::ST_KEYLOAD: begin
                do_byte = 1'b1;
                feed = r_key[255 - 8*r_idx[4:0] -: 8];
            end
            scd_pkg::ST_BYTE: begin
                do_byte = 1'b1;
                feed = i_cmd.data;
                o_cmd_rd = 1'b1;
            end
            scd_pkg::ST_CTR: begin
                do_byte = 1'b1;
                feed = r_ctr[31 - 8*r_idx[1:0] -: 8];
            end
            scd_pkg::ST_COMP: comp_start = 1'b1;
            default: ;
        endcase
    end

    // padding: 0x80 at pos, zeros, length in last 8 bytes unless spill
    assign pad_two = (pos > 6'd55);
    always_comb begin
        pad_blk = r_buf;
        for (int i = 0; i < 64; i++) begin
            if (6'(i) == pos) pad_blk[511-8*i -: 8] = 8'h80;
            else if (6'(i) > pos) pad_blk[511-8*i -: 8] = 8'h00;
        end
        if (!pad_two) pad_blk[63:0] = r_len;
    end

    assign o_empty = !(r_st == scd_pkg::ST_EMIT);
    assign o_random_word = r_out[255 - 64*r_oc[1:0] -: 64];
    assign o_word_last = (r_oc == 3'd3);
    assign o_was_seeded = r_seeded;

    always_ff @(posedge i_clk) begin
        if (do_byte) r_buf[511 - 8*pos -: 8] <= feed;
        if (r_st == scd_pkg::ST_PAD) begin
            if (r_oval) r_buf <= {448'd0, r_len};
            else r_buf <= pad_blk;
        end
        if (r_st == scd_pkg::ST_COMP_WAIT && comp_done) r_chain <= comp_out;
        if (r_st == scd_pkg::ST_DONE_OUT) r_out <= r_chain;
        if (!i_rst_n) begin
            r_st <= scd_pkg::ST_IDLE;
            r_key <= '0;
            r_chain <= scd_pkg::ChainIv;
            r_len <= '0;
            r_ctr <= '0;
            r_seeded <= 1'b0;
            r_active <= 1'b0;
            r_gen <= 1'b0;
            r_rekey <= 1'b0;
            r_fin <= 1'b0;
            r_idx <= '0;
            r_oc <= '0;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (do_byte) r_len <= r_len + 64'd8;
            if (r_st == scd_pkg::ST_KEYLOAD || r_st == scd_pkg::ST_CTR)
                r_idx <= (n_st == r_st) ? r_idx + 1'b1 : '0;
            case (r_st)
                scd_pkg::ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        if (i_cmd.op == scd_pkg::OP_GENERATE || !r_active) begin
                            r_chain <= scd_pkg::ChainIv;
                            r_len <= '0;
                        end
                        r_gen <= (i_cmd.op == scd_pkg::OP_GENERATE);
                        r_rekey <= 1'b0;
                        r_fin <= 1'b0;
                        r_active <= (i_cmd.op == scd_pkg::OP_ABSORB);
                        r_idx <= '0;
                    end
                end
                scd_pkg::ST_BYTE: begin
                    if (i_cmd.last) r_active <= 1'b0;
                end
                scd_pkg::ST_PAD: begin
                    r_oval <= !r_oval && pad_two;
                    r_fin <= 1'b1;
                end
                scd_pkg::ST_DONE_SEED: begin
                    r_key <= r_chain;
                    r_ctr <= '0;
                    r_seeded <= 1'b1;
                end
                scd_pkg::ST_DONE_OUT: begin
                    r_chain <= scd_pkg::ChainIv;
                    r_len <= '0;
                    r_rekey <= 1'b1;
                end
                scd_pkg::ST_REKEY: begin
                    r_key <= r_chain;
                    r_ctr <= r_ctr + 1'b1;
                    r_oc <= '0;
                end
                scd_pkg::ST_EMIT: if (i_pop) r_oc <= r_oc + 1'b1;
                default: ;
            endcase
        end
    end

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> r_oc <= 3'd3) else $error("word index out of range");
    a_rd_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_rd |-> !i_cmd_empty) else $error("read from empty queue");
    a_seed_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == scd_pkg::ST_DONE_SEED |=> r_ctr == '0) else $error("counter not cleared");
endmodule
`default_nettype wire

>>> hw/rtl/sha256_counter_drbg_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_counter_drbg_core: SHA-256 counter-mode random generator
// Generate: two 64-round compressions (key and counter bytes, then the key for
// rekeying) precede the first word; absorb loads each byte, compresses each full
// block, first loads the old key if seeded, then pads to finish (twice on spill).
// Throughput: one item at a time, bound by the single round unit.
// Reset: synchronous active low; key zero, unseeded, counter zero, queue empty.
// ----------------------------------------------------------------------------
module sha256_counter_drbg_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_entropy_byte,
    input  wire logic        i_entropy_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      o_random_word,
    output logic             o_word_last,
    output logic             o_was_seeded
);
    scd_pkg::t_cmd in_cmd, q_cmd;
    logic q_empty, q_rd;

    always_comb begin
        in_cmd.op = scd_pkg::t_op'(i_op);
        in_cmd.data = i_entropy_byte;
        in_cmd.last = i_entropy_last;
    end

    scd_cmd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(push), .i_cmd(in_cmd), .o_full(full),
        .i_rd(q_rd), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    scd_engine u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_empty(q_empty), .i_cmd(q_cmd),
        .o_cmd_rd(q_rd), .o_empty(empty), .i_pop(pop), .o_random_word(o_random_word),
        .o_word_last(o_word_last), .o_was_seeded(o_was_seeded)
    );
endmodule
`default_nettype wire
